>>> hdl/pyr_pkg.sv
// Shared types, constants and the divider step for the pyramid shape function evaluator.
package pyr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 18;
  localparam int IDX_W     = 3;
  localparam int THR_W     = 16;
  localparam int OUT_W     = 21;

  localparam int DEN_W  = COORD_W;            // |1 - t| stays below 2^18
  localparam int PROD_W = 2 * COORD_W;        // r*s, s*t, r*t
  localparam int FP_W   = 2 * (COORD_W + 1);  // (1+-r)(1+-s)
  localparam int RST_W  = 3 * COORD_W;        // r*s*t
  localparam int BASE_W = 24;
  localparam int Q1_W   = 38;                 // u, rdr, rds, ration quotients
  localparam int Q2_W   = 41;                 // rdt quotient, clipped at 2^40
  localparam int NT_W   = Q1_W + FRAC_BITS + 1;

  localparam int FRONT_REGS = 4;
  localparam int DIV1_STEPS = Q1_W;
  localparam int DIV2_STEPS = Q2_W;
  localparam int BACK_REGS  = 2;
  localparam int PIPE_DEPTH = FRONT_REGS + DIV1_STEPS + 1 + DIV2_STEPS + BACK_REGS;

  localparam logic [IDX_W-1:0] IDX_CORNER_FIRST = 3'd0;
  localparam logic [IDX_W-1:0] IDX_CORNER_LAST  = 3'd3;
  localparam logic [IDX_W-1:0] IDX_APEX         = 3'd4;

  typedef logic signed [COORD_W-1:0] crd_t;
  typedef logic signed [OUT_W-1:0]   res_t;
  typedef logic [DEN_W-1:0]          den_t;
  typedef logic [Q1_W-1:0]           q1_t;

  typedef struct packed {
    logic [IDX_W-1:0]          idx;
    logic                      apex;
    logic                      dneg;
    logic                      neg_u;
    logic                      neg_rdr;
    logic                      neg_rds;
    logic                      neg_ra;
    crd_t                      t;
    logic signed [BASE_W-1:0]  base;
    logic signed [COORD_W:0]   fr;
    logic signed [COORD_W:0]   fs;
  } side_t;

  typedef struct packed {
    q1_t u;
    q1_t rdr;
    q1_t rds;
    q1_t ra;
  } quad_t;

  typedef struct packed {
    side_t side;
    q1_t   q_rdr;
    q1_t   q_rds;
    q1_t   q_ra;
    logic  ovf;
  } mid_t;

  // One restoring step: shift in a dividend bit, subtract when it fits.
  // Returns {quotient bit, new remainder}.
  function automatic logic [DEN_W:0] div_step(input den_t rem, input logic nbit,
                                              input den_t den);
    logic [DEN_W:0] acc;
    acc = {rem, nbit};
    if (acc >= {1'b0, den}) begin
      div_step = {1'b1, DEN_W'(acc - {1'b0, den})};
    end else begin
      div_step = {1'b0, acc[DEN_W-1:0]};
    end
  endfunction

endpackage

>>> hdl/pyramid_shape_function_eval.sv
// Top level of the linear pyramid shape function evaluator.
//
//  channel   signals                                         direction  flow
//  -------   ----------------------------------------------  ---------  -------------------
//  command   start, busy, coord_r, coord_s, coord_t,          in         beat on start & !busy
//            basis_index
//  result    done, shape_value, grad_r, grad_s, grad_t,       out        beat on done, 1 cycle
//            saturated
//  config    cfg_we, cfg_data (apex_threshold)                in         write on cfg_we
//
//  One beat per cycle, sustained. Each beat comes out in the order it is taken;
//  the pipeline depth is set by the two bit-per-stage dividers (38 + 41 stages)
//  plus the multiplier front end and the rounding back end.
//  rst is synchronous and flushes every beat in flight; busy is high only during rst.
//  Nothing stalls: the pipeline moves every cycle and done is a one-cycle strobe.
//
//  Datapath:
//   front : capture, r*s / s*t / r*t / corner product, then r*s*t, then the
//           numerators |4rs|+d/2, |4st|+d/2, |4rt|+d/2, (|4rst|+S*d/2)/S
//   div1  : four restoring dividers by |1-t| in lockstep -> u, rdr, rds, ration
//   div2  : |u|*S + d/2 divided by |1-t| -> rdt, with overflow into the 2^40 clip
//   back  : signs, apex override, sums, round /16, saturate to Q4.16
module pyramid_shape_function_eval (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pyr_pkg::crd_t       coord_r,
  input  pyr_pkg::crd_t       coord_s,
  input  pyr_pkg::crd_t       coord_t,
  input  logic [2:0]          basis_index,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output logic                done,
  output pyr_pkg::res_t       shape_value,
  output pyr_pkg::res_t       grad_r,
  output pyr_pkg::res_t       grad_s,
  output pyr_pkg::res_t       grad_t,
  output logic                saturated
);
  import pyr_pkg::*;

  logic [THR_W-1:0] apex_threshold;
  logic             in_vld;

  logic   f_vld;
  den_t   f_den;
  side_t  f_side;
  quad_t  f_num;

  logic   d1_vld;
  den_t   d1_den;
  side_t  d1_side;
  quad_t  d1_quo;

  logic            d2_vld;
  mid_t            d2_mid;
  logic [Q2_W-1:0] d2_qt;

  // config register; to be written by the user only while no beat is in flight, which the block leaves unchecked
  always_ff @(posedge clk) begin
    if (rst) begin
      apex_threshold <= '0;
    end else if (cfg_we) begin
      apex_threshold <= cfg_data;
    end
  end

  // the pipeline never backs up, so a command is refused only in reset
  assign busy   = rst;
  assign in_vld = start & ~busy;

  pyr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (in_vld),
    .in_r     (coord_r),
    .in_s     (coord_s),
    .in_t     (coord_t),
    .in_idx   (basis_index),
    .thr      (apex_threshold),
    .out_vld  (f_vld),
    .out_den  (f_den),
    .out_side (f_side),
    .out_num  (f_num)
  );

  pyr_div1 u_div1 (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .in_den   (f_den),
    .in_side  (f_side),
    .in_num   (f_num),
    .out_vld  (d1_vld),
    .out_den  (d1_den),
    .out_side (d1_side),
    .out_quo  (d1_quo)
  );

  pyr_div2 u_div2 (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (d1_vld),
    .in_den  (d1_den),
    .in_side (d1_side),
    .in_quo  (d1_quo),
    .out_vld (d2_vld),
    .out_mid (d2_mid),
    .out_qt  (d2_qt)
  );

  pyr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_vld      (d2_vld),
    .in_mid      (d2_mid),
    .in_qt       (d2_qt),
    .done        (done),
    .shape_value (shape_value),
    .grad_r      (grad_r),
    .grad_s      (grad_s),
    .grad_t      (grad_t),
    .saturated   (saturated)
  );

endmodule

>>> hdl/pyr_front.sv
// Front end: input capture, products, rounding of the base term and divider numerators.
module pyr_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  pyr_pkg::crd_t           in_r,
  input  pyr_pkg::crd_t           in_s,
  input  pyr_pkg::crd_t           in_t,
  input  logic [2:0]              in_idx,
  input  logic [15:0]             thr,
  output logic                    out_vld,
  output pyr_pkg::den_t           out_den,
  output pyr_pkg::side_t          out_side,
  output pyr_pkg::quad_t          out_num
);
  import pyr_pkg::*;

  localparam logic signed [COORD_W:0] ONE = (COORD_W + 1)'(2 ** FRAC_BITS);
  localparam int NR_W = RST_W + 2;

  // stage 0
  logic             v0;
  crd_t             r0, s0, t0;
  logic [IDX_W-1:0] idx0;
  logic signed [COORD_W:0] d0, fr0, fs0;
  den_t             dmag0;
  logic             apex0;

  // stage 1
  logic                    v1;
  logic signed [PROD_W-1:0] rs1, st1, rt1;
  logic signed [FP_W-1:0]   fp1;
  crd_t                    t1;
  logic [IDX_W-1:0]        idx1;
  logic                    apex1, dneg1;
  den_t                    dmag1;
  logic signed [COORD_W:0] fr1, fs1;
  logic signed [RST_W-1:0] rst_c;
  logic [FP_W-1:0]         fpmag;
  logic [BASE_W-1:0]       bq;
  logic signed [BASE_W-1:0] base_c;

  // stage 2
  logic                    v2;
  logic signed [PROD_W-1:0] rs2, st2, rt2;
  logic signed [RST_W-1:0] rst2;
  logic signed [BASE_W-1:0] base2;
  crd_t                    t2;
  logic [IDX_W-1:0]        idx2;
  logic                    apex2, dneg2;
  den_t                    dmag2;
  logic signed [COORD_W:0] fr2, fs2;
  logic [PROD_W-1:0]       rsm, stm, rtm;
  logic [RST_W-1:0]        rstm;
  logic [NR_W-1:0]         nra;
  quad_t                   num_c;
  side_t                   side_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_vld;
    end
    r0   <= in_r;
    s0   <= in_s;
    t0   <= in_t;
    idx0 <= in_idx;
  end

  // index bit 0 picks the sign of r, bit 1 the sign of s
  always_comb begin
    d0    = ONE - (COORD_W + 1)'(t0);
    dmag0 = d0[COORD_W] ? DEN_W'(-d0) : DEN_W'(d0);
    apex0 = dmag0 <= DEN_W'(thr);
    fr0   = idx0[0] ? ONE + (COORD_W + 1)'(r0) : ONE - (COORD_W + 1)'(r0);
    fs0   = idx0[1] ? ONE + (COORD_W + 1)'(s0) : ONE - (COORD_W + 1)'(s0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    rs1   <= PROD_W'(r0) * PROD_W'(s0);
    st1   <= PROD_W'(s0) * PROD_W'(t0);
    rt1   <= PROD_W'(r0) * PROD_W'(t0);
    fp1   <= FP_W'(fr0) * FP_W'(fs0);
    t1    <= t0;
    idx1  <= idx0;
    apex1 <= apex0;
    dneg1 <= d0[COORD_W];
    dmag1 <= dmag0;
    fr1   <= fr0;
    fs1   <= fs0;
  end

  // base = rnd(4*(1+-r)(1+-s)), ties away from zero
  always_comb begin
    rst_c  = RST_W'(rs1) * RST_W'(t1);
    fpmag  = fp1[FP_W-1] ? FP_W'(-fp1) : FP_W'(fp1);
    bq     = BASE_W'((fpmag + FP_W'(2 ** (FRAC_BITS - 3))) >> (FRAC_BITS - 2));
    base_c = fp1[FP_W-1] ? -$signed(bq) : $signed(bq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    rs2   <= rs1;
    st2   <= st1;
    rt2   <= rt1;
    rst2  <= rst_c;
    base2 <= base_c;
    t2    <= t1;
    idx2  <= idx1;
    apex2 <= apex1;
    dneg2 <= dneg1;
    dmag2 <= dmag1;
    fr2   <= fr1;
    fs2   <= fs1;
  end

  // numerators as magnitudes with half the divisor folded in
  always_comb begin
    rsm  = rs2[PROD_W-1] ? PROD_W'(-rs2) : PROD_W'(rs2);
    stm  = st2[PROD_W-1] ? PROD_W'(-st2) : PROD_W'(st2);
    rtm  = rt2[PROD_W-1] ? PROD_W'(-rt2) : PROD_W'(rt2);
    rstm = rst2[RST_W-1] ? RST_W'(-rst2) : RST_W'(rst2);
    num_c.u   = Q1_W'({rsm, 2'b00}) + Q1_W'(dmag2 >> 1);
    num_c.rdr = Q1_W'({stm, 2'b00}) + Q1_W'(dmag2 >> 1);
    num_c.rds = Q1_W'({rtm, 2'b00}) + Q1_W'(dmag2 >> 1);
    // ration divides by S*d: fold S into the dividend
    nra       = {rstm, 2'b00} + (NR_W'(dmag2) << (FRAC_BITS - 1));
    num_c.ra  = Q1_W'(nra >> FRAC_BITS);
    side_c.idx     = idx2;
    side_c.apex    = apex2;
    side_c.dneg    = dneg2;
    side_c.neg_u   = rs2[PROD_W-1] ^ dneg2;
    side_c.neg_rdr = st2[PROD_W-1] ^ dneg2;
    side_c.neg_rds = rt2[PROD_W-1] ^ dneg2;
    side_c.neg_ra  = rst2[RST_W-1] ^ dneg2;
    side_c.t       = t2;
    side_c.base    = base2;
    side_c.fr      = fr2;
    side_c.fs      = fs2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= v2;
    end
    out_den  <= dmag2;
    out_num  <= num_c;
    out_side <= side_c;
  end

endmodule

>>> hdl/pyr_div1.sv
// Four-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
module pyr_div1 (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  pyr_pkg::den_t   in_den,
  input  pyr_pkg::side_t  in_side,
  input  pyr_pkg::quad_t  in_num,
  output logic            out_vld,
  output pyr_pkg::den_t   out_den,
  output pyr_pkg::side_t  out_side,
  output pyr_pkg::quad_t  out_quo
);
  import pyr_pkg::*;

  typedef struct packed {
    den_t u;
    den_t rdr;
    den_t rds;
    den_t ra;
  } rem4_t;

  logic  vld_q  [1:DIV1_STEPS];
  den_t  den_q  [1:DIV1_STEPS];
  side_t side_q [1:DIV1_STEPS];
  quad_t num_q  [1:DIV1_STEPS];
  rem4_t rem_q  [1:DIV1_STEPS];

  for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_step
    logic           c_vld;
    den_t           c_den;
    side_t          c_side;
    quad_t          c_num, n_num;
    rem4_t          c_rem, n_rem;
    logic [DEN_W:0] su, sr, ss, sa;

    if (k == 0) begin : g_head
      assign c_vld  = in_vld;
      assign c_den  = in_den;
      assign c_side = in_side;
      assign c_num  = in_num;
      assign c_rem  = '0;
    end else begin : g_body
      assign c_vld  = vld_q[k];
      assign c_den  = den_q[k];
      assign c_side = side_q[k];
      assign c_num  = num_q[k];
      assign c_rem  = rem_q[k];
    end

    always_comb begin
      su = div_step(c_rem.u,   c_num.u[Q1_W-1],   c_den);
      sr = div_step(c_rem.rdr, c_num.rdr[Q1_W-1], c_den);
      ss = div_step(c_rem.rds, c_num.rds[Q1_W-1], c_den);
      sa = div_step(c_rem.ra,  c_num.ra[Q1_W-1],  c_den);
      n_num.u   = {c_num.u[Q1_W-2:0],   su[DEN_W]};
      n_num.rdr = {c_num.rdr[Q1_W-2:0], sr[DEN_W]};
      n_num.rds = {c_num.rds[Q1_W-2:0], ss[DEN_W]};
      n_num.ra  = {c_num.ra[Q1_W-2:0],  sa[DEN_W]};
      n_rem.u   = su[DEN_W-1:0];
      n_rem.rdr = sr[DEN_W-1:0];
      n_rem.rds = ss[DEN_W-1:0];
      n_rem.ra  = sa[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= c_vld;
      end
      den_q[k+1]  <= c_den;
      side_q[k+1] <= c_side;
      num_q[k+1]  <= n_num;
      rem_q[k+1]  <= n_rem;
    end
  end

  assign out_vld  = vld_q[DIV1_STEPS];
  assign out_den  = den_q[DIV1_STEPS];
  assign out_side = side_q[DIV1_STEPS];
  assign out_quo  = num_q[DIV1_STEPS];

endmodule

>>> hdl/pyr_div2.sv
// Second divider: rdt = rnd(u*S/d) with overflow detect, one quotient bit per stage.
module pyr_div2 (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  pyr_pkg::den_t         in_den,
  input  pyr_pkg::side_t        in_side,
  input  pyr_pkg::quad_t        in_quo,
  output logic                  out_vld,
  output pyr_pkg::mid_t         out_mid,
  output logic [pyr_pkg::Q2_W-1:0] out_qt
);
  import pyr_pkg::*;

  localparam int HI_W = NT_W - Q2_W;

  logic [NT_W-1:0] nt;
  logic [HI_W-1:0] hi;
  mid_t            mid_c;

  logic            vld_q [0:DIV2_STEPS];
  den_t            den_q [0:DIV2_STEPS];
  mid_t            mid_q [0:DIV2_STEPS];
  logic [Q2_W-1:0] num_q [0:DIV2_STEPS];
  den_t            rem_q [0:DIV2_STEPS];

  // |u|*S + d/2; the bits above the quotient width seed the remainder
  always_comb begin
    nt          = NT_W'({in_quo.u, FRAC_BITS'(0)}) + NT_W'(in_den >> 1);
    hi          = nt[NT_W-1:Q2_W];
    mid_c.side  = in_side;
    mid_c.q_rdr = in_quo.rdr;
    mid_c.q_rds = in_quo.rds;
    mid_c.q_ra  = in_quo.ra;
    mid_c.ovf   = DEN_W'(hi) >= in_den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_vld;
    end
    den_q[0] <= in_den;
    mid_q[0] <= mid_c;
    num_q[0] <= nt[Q2_W-1:0];
    rem_q[0] <= DEN_W'(hi);
  end

  for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_step
    logic [DEN_W:0] st;

    always_comb begin
      st = div_step(rem_q[k], num_q[k][Q2_W-1], den_q[k]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
      den_q[k+1] <= den_q[k];
      mid_q[k+1] <= mid_q[k];
      num_q[k+1] <= {num_q[k][Q2_W-2:0], st[DEN_W]};
      rem_q[k+1] <= st[DEN_W-1:0];
    end
  end

  assign out_vld = vld_q[DIV2_STEPS];
  assign out_mid = mid_q[DIV2_STEPS];
  assign out_qt  = num_q[DIV2_STEPS];

endmodule

>>> hdl/pyr_back.sv
// Back end: signs, apex override, term sums, final rounding and saturation.
module pyr_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_vld,
  input  pyr_pkg::mid_t            in_mid,
  input  logic [pyr_pkg::Q2_W-1:0] in_qt,
  output logic                     done,
  output pyr_pkg::res_t            shape_value,
  output pyr_pkg::res_t            grad_r,
  output pyr_pkg::res_t            grad_s,
  output pyr_pkg::res_t            grad_t,
  output logic                     saturated
);
  import pyr_pkg::*;

  localparam int SUM_W = 44;
  localparam logic signed [SUM_W-1:0] ONE4    = SUM_W'(2 ** (FRAC_BITS + 2));
  localparam logic [Q2_W-1:0]         TERM_LIM = Q2_W'(64'd1 << 40);
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = ~OUT_MAX;
  localparam res_t                    ONE_OUT = OUT_W'(2 ** FRAC_BITS);

  typedef struct packed {
    logic flag;
    res_t val;
  } rs_t;

  function automatic logic signed [SUM_W-1:0] signed_mag(input logic neg,
                                                         input logic [Q2_W-1:0] mag);
    logic signed [SUM_W-1:0] m;
    m = SUM_W'(mag);
    signed_mag = neg ? -m : m;
  endfunction

  // divide by 16, ties away from zero, clip to the output range
  function automatic rs_t rnd_sat(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-1:0]        mag;
    logic [SUM_W-1:0]        q;
    logic signed [SUM_W-1:0] y;
    mag = x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
    q   = (mag + SUM_W'(8)) >> 4;
    y   = x[SUM_W-1] ? -$signed(q) : $signed(q);
    if (y > OUT_MAX) begin
      rnd_sat = {1'b1, OUT_MAX[OUT_W-1:0]};
    end else if (y < OUT_MIN) begin
      rnd_sat = {1'b1, OUT_MIN[OUT_W-1:0]};
    end else begin
      rnd_sat = {1'b0, y[OUT_W-1:0]};
    end
  endfunction

  side_t                   sd;
  logic                    par_neg;
  logic [Q2_W-1:0]         rdt_mag;
  logic signed [SUM_W-1:0] ra, rdr, rds, rdt, fr4, fs4;
  logic signed [SUM_W-1:0] v_c, gr_c, gs_c, gt_c;

  logic                    b_vld;
  logic [IDX_W-1:0]        b_idx;
  crd_t                    b_t;
  logic signed [SUM_W-1:0] b_v, b_gr, b_gs, b_gt;
  rs_t                     o_v, o_gr, o_gs, o_gt;

  always_comb begin
    sd      = in_mid.side;
    par_neg = sd.idx[0] ^ sd.idx[1];
    rdt_mag = (in_mid.ovf || in_qt > TERM_LIM) ? TERM_LIM : in_qt;
    if (sd.apex) begin
      ra  = '0;
      rdr = ONE4;
      rds = ONE4;
      rdt = ONE4;
    end else begin
      ra  = signed_mag(sd.neg_ra,  Q2_W'(in_mid.q_ra));
      rdr = signed_mag(sd.neg_rdr, Q2_W'(in_mid.q_rdr));
      rds = signed_mag(sd.neg_rds, Q2_W'(in_mid.q_rds));
      rdt = signed_mag(sd.neg_u ^ sd.dneg, rdt_mag);
    end
    if (par_neg) begin
      ra  = -ra;
      rdr = -rdr;
      rds = -rds;
      rdt = -rdt;
    end
    fr4  = SUM_W'(sd.fr) <<< 2;
    fs4  = SUM_W'(sd.fs) <<< 2;
    v_c  = SUM_W'(sd.base) - (SUM_W'(sd.t) <<< 2) + ra;
    gr_c = (sd.idx[0] ? fs4 : -fs4) + rdr;
    gs_c = (sd.idx[1] ? fr4 : -fr4) + rds;
    gt_c = rdt - ONE4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= in_vld;
    end
    b_idx <= sd.idx;
    b_t   <= sd.t;
    b_v   <= v_c;
    b_gr  <= gr_c;
    b_gs  <= gs_c;
    b_gt  <= gt_c;
  end

  always_comb begin
    o_v  = rnd_sat(b_v);
    o_gr = rnd_sat(b_gr);
    o_gs = rnd_sat(b_gs);
    o_gt = rnd_sat(b_gt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_vld;
    end
    case (b_idx) inside
      [IDX_CORNER_FIRST:IDX_CORNER_LAST]: begin
        shape_value <= o_v.val;
        grad_r      <= o_gr.val;
        grad_s      <= o_gs.val;
        grad_t      <= o_gt.val;
        saturated   <= o_v.flag | o_gr.flag | o_gs.flag | o_gt.flag;
      end
      IDX_APEX: begin
        shape_value <= OUT_W'(b_t);
        grad_r      <= '0;
        grad_s      <= '0;
        grad_t      <= ONE_OUT;
        saturated   <= 1'b0;
      end
      default: begin
        shape_value <= '0;
        grad_r      <= '0;
        grad_s      <= '0;
        grad_t      <= '0;
        saturated   <= 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/pyr_checker.sv
// Port-level checks for the pyramid shape function evaluator, bound to the top level.
module pyr_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input pyr_pkg::res_t shape_value,
  input pyr_pkg::res_t grad_r,
  input pyr_pkg::res_t grad_s,
  input pyr_pkg::res_t grad_t,
  input logic          saturated
);
  import pyr_pkg::*;

  localparam res_t RMAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam res_t RMIN = {1'b1, {(OUT_W - 1){1'b0}}};

  a_reset_flush : assert property (@(posedge clk) rst |=> !done)
    else $error("result beat right after reset");

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("accepted beat did not come out on time");

  a_no_orphan : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result beat with no matching command");

  a_sat_clip : assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (shape_value == RMAX || shape_value == RMIN || grad_r == RMAX || grad_r == RMIN ||
       grad_s == RMAX || grad_s == RMIN || grad_t == RMAX || grad_t == RMIN))
    else $error("saturated flag without a clipped field");

endmodule

bind pyramid_shape_function_eval pyr_checker u_chk (.*);
